// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and idle during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ree_pkg.sv =====
// ----------------------------------------------------------------------------
// ree_pkg
// types and constants shared by the rotary encoder event detector
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ree_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_NOTCH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BUTTON_PRESENT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TICKS         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_CLICK_TICKS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PRESS_TICKS    = 3'd5;

    // detent modes
    localparam logic [2:0] NOTCH_STEPS_FOUR = 3'd4;
    localparam logic [2:0] NOTCH_STEPS_TWO  = 3'd2;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_LEFT   = 3'd1,
        EV_RIGHT  = 3'd2,
        EV_CLICK  = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_HOLD   = 3'd5
    } event_t;

    typedef struct packed {
        logic [2:0]  steps_per_notch;
        logic        active_level;
        logic        button_present;
        logic [15:0] hold_ticks;
        logic [7:0]  double_click_ticks;
        logic [15:0] min_press_ticks;
    } cfg_t;

    typedef struct packed {
        logic mode;
        logic phase_a;
        logic phase_b;
        logic button_level;
        logic button_tick;
    } sample_t;

endpackage

`default_nettype wire

// ===== hdl/ree_if.sv =====
// ----------------------------------------------------------------------------
// ree_if
// valid/ready channels for encoder samples and detected events
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ree_sample_if;
    logic valid;
    logic ready;
    logic mode;
    logic phase_a;
    logic phase_b;
    logic button_level;
    logic button_tick;

    modport source (
        output valid, mode, phase_a, phase_b, button_level, button_tick,
        input  ready
    );
    modport sink (
        input  valid, mode, phase_a, phase_b, button_level, button_tick,
        output ready
    );
endinterface

interface ree_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;

    modport source (
        output valid, event_res,
        input  ready
    );
    modport sink (
        input  valid, event_res,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/rotary_encoder_button_events.sv =====
// ----------------------------------------------------------------------------
// rotary_encoder_button_events
// quadrature encoder and push-button event detector
//
// samples arrive on the sample channel (valid/ready): mode, both encoder
// phases, the raw button level and a tick flag for each button check interval.
// each sample yields exactly one event code on the result channel:
// 0 none, 1 left, 2 right, 3 click, 4 double click, 5 hold. mode 1 clears the
// current event to none without sampling anything.
// the configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per cycle; write it only while no sample is in flight.
// a transferred sample sits in the input register, is processed from there
// and its event is loaded into the result register once that register is free.
// throughput is one sample per cycle while results are taken, set by
// the single phase and button update pass between input and result registers.
// a stalled result holds in the result register, the input register takes one
// more sample and then sample.ready drops until the result is taken.
// reset clears encoder, button and event state and restores default settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rotary_encoder_button_events
    import ree_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    ree_sample_if.sink                  sample,
    ree_event_if.source                 result
);

    cfg_t    cfg;
    event_t  event_calc;

    // input register
    logic    in_valid_reg, in_valid_next;
    sample_t in_item_reg;
    sample_t in_item_in;

    // result register
    logic    out_valid_reg, out_valid_next;
    event_t  out_event_reg;

    logic    in_xfer;
    logic    advance;
    logic    fire;

    // result register can load when empty or being drained this cycle
    assign advance = !out_valid_reg || result.ready;
    assign fire    = in_valid_reg && advance;

    // take a new sample whenever the held one moves on
    assign sample.ready = !in_valid_reg || advance;
    assign in_xfer      = sample.valid && sample.ready;

    assign in_item_in = '{
        mode:         sample.mode,
        phase_a:      sample.phase_a,
        phase_b:      sample.phase_b,
        button_level: sample.button_level,
        button_tick:  sample.button_tick
    };

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_xfer)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_item_reg <= in_item_in;
        if (fire)
            out_event_reg <= event_calc;
    end

    ree_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // encoder and button state, updated once per processed sample
    ree_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .item      (in_item_reg),
        .event_out (event_calc)
    );

    assign result.valid     = out_valid_reg;
    assign result.event_res = out_event_reg;

    `ASSERT_NEXT(a_fire_gives_result, fire, out_valid_reg, "processed sample produced no result")
    `ASSERT_NEXT(a_held_sample_kept, in_valid_reg && !fire, in_valid_reg, "held sample dropped before processing")
    `ASSERT_SAME(a_no_overwrite, in_xfer, !in_valid_reg || fire, "new sample overwrote a held one")

endmodule

`default_nettype wire

// ===== hdl/ree_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ree_cfg_regs
// configuration register file, written by index, reset to default settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ree_cfg_regs
    import ree_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEPS_PER_NOTCH:    cfg_next.steps_per_notch    = cfg_wdata[2:0];
                REG_ACTIVE_LEVEL:       cfg_next.active_level       = cfg_wdata[0];
                REG_BUTTON_PRESENT:     cfg_next.button_present     = cfg_wdata[0];
                REG_HOLD_TICKS:         cfg_next.hold_ticks         = cfg_wdata;
                REG_DOUBLE_CLICK_TICKS: cfg_next.double_click_ticks = cfg_wdata[7:0];
                REG_MIN_PRESS_TICKS:    cfg_next.min_press_ticks    = cfg_wdata;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.steps_per_notch    <= 3'd4;
            cfg_reg.active_level       <= 1'b0;
            cfg_reg.button_present     <= 1'b1;
            cfg_reg.hold_ticks         <= 16'd100;
            cfg_reg.double_click_ticks <= 8'd60;
            cfg_reg.min_press_ticks    <= 16'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hdl/ree_core.sv =====
// ----------------------------------------------------------------------------
// ree_core
// encoder and button state, updated once per processed sample
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ree_core
    import ree_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    fire,
    input  wire sample_t item,
    output event_t       event_out
);

    logic [1:0]  last_phase_reg, last_phase_next;
    logic [3:0]  step_acc_reg,   step_acc_next;
    logic [15:0] key_down_reg,   key_down_next;
    logic [7:0]  dclick_reg,     dclick_next;
    event_t      event_reg,      event_next;

    logic              a_act;
    logic              b_act;
    logic [1:0]        phase_code;
    logic [1:0]        phase_diff;
    logic signed [4:0] step_delta;
    logic signed [4:0] acc;
    logic              move_left;
    logic              move_right;

    // phase decode and step direction
    always_comb
    begin
        a_act      = (item.phase_a == cfg.active_level);
        b_act      = (item.phase_b == cfg.active_level);
        phase_code = {a_act, a_act ^ b_act};
        phase_diff = last_phase_reg - phase_code;
        if (!phase_diff[0])
            step_delta = 5'sd0;
        else if (phase_diff[1])
            step_delta = 5'sd1;
        else
            step_delta = -5'sd1;
        acc = $signed({step_acc_reg[3], step_acc_reg}) + step_delta;
    end

    always_comb
    begin
        last_phase_next = last_phase_reg;
        step_acc_next   = step_acc_reg;
        key_down_next   = key_down_reg;
        dclick_next     = dclick_reg;
        event_next      = event_reg;
        move_left       = 1'b0;
        move_right      = 1'b0;

        if (item.mode)
        begin
            event_next = EV_NONE;
        end
        else
        begin
            if (phase_diff[0])
                last_phase_next = phase_code;

            // button timing, only on check ticks and when a button is present
            if (cfg.button_present && item.button_tick)
            begin
                if (item.button_level != cfg.active_level)
                begin
                    key_down_next = key_down_reg + 16'd1;
                    if (key_down_next > cfg.hold_ticks)
                        event_next = EV_HOLD;
                end
                else
                begin
                    if (key_down_reg > cfg.min_press_ticks)
                    begin
                        if (event_reg == EV_HOLD)
                        begin
                            event_next  = EV_NONE;
                            dclick_next = 8'd0;
                        end
                        else if (dclick_reg > 8'd1)
                        begin
                            if (dclick_reg < cfg.double_click_ticks)
                            begin
                                event_next  = EV_DOUBLE;
                                dclick_next = 8'd0;
                            end
                        end
                        else
                        begin
                            dclick_next = cfg.double_click_ticks;
                        end
                    end
                    key_down_next = 16'd0;
                end
                // countdown by two, wrapping past zero on an odd count
                if (dclick_next != 8'd0)
                begin
                    dclick_next = dclick_next - 8'd2;
                    if (dclick_next == 8'd0)
                        event_next = EV_CLICK;
                end
            end

            // residue and detent movement
            case (cfg.steps_per_notch)
                NOTCH_STEPS_FOUR:
                begin
                    step_acc_next = {2'b00, acc[1:0]};
                    move_left     = acc < 5'sd0;
                    move_right    = acc > 5'sd3;
                end
                NOTCH_STEPS_TWO:
                begin
                    step_acc_next = {3'b000, acc[0]};
                    move_left     = acc < 5'sd0;
                    move_right    = acc > 5'sd1;
                end
                default:
                begin
                    step_acc_next = 4'd0;
                    move_left     = acc < 5'sd0;
                    move_right    = acc > 5'sd0;
                end
            endcase

            // rotation wins over any button event
            if (move_left)
                event_next = EV_LEFT;
            else if (move_right)
                event_next = EV_RIGHT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= 2'd0;
            step_acc_reg   <= 4'd0;
            key_down_reg   <= 16'd0;
            dclick_reg     <= 8'd0;
            event_reg      <= EV_NONE;
        end
        else if (fire)
        begin
            last_phase_reg <= last_phase_next;
            step_acc_reg   <= step_acc_next;
            key_down_reg   <= key_down_next;
            dclick_reg     <= dclick_next;
            event_reg      <= event_next;
        end
    end

    assign event_out = event_next;

    `ASSERT_NEXT(a_clear_sets_none, fire && item.mode, event_reg == EV_NONE,
                 "clear did not reset event")
    `ASSERT_NEXT(a_two_step_residue,
                 fire && !item.mode && cfg.steps_per_notch == NOTCH_STEPS_TWO,
                 step_acc_reg[3:1] == 3'd0,
                 "residue out of range for two steps per notch")
    `ASSERT_NEXT(a_idle_holds_state, !fire,
                 $stable(event_reg) && $stable(key_down_reg) && $stable(dclick_reg),
                 "state moved without a sample")

endmodule

`default_nettype wire
